// ----- src/slch_pkg.sv -----
`default_nettype none

package slch_pkg;

    typedef logic [26:0] hash_t;
    typedef logic [2:0]  verdict_t;

    localparam int unsigned POS_W = 13;

    localparam hash_t       HASH_MOD      = 27'd82595524;
    localparam logic [28:0] HASH_MOD2     = {1'b0, HASH_MOD, 1'b0};
    localparam logic [27:0] HASH_MU       = 28'((64'd1 << 54) / 64'd82595524);
    localparam hash_t       HASH_BASE     = 27'd26;
    localparam logic [6:0]  LETTER_OFFSET = 7'd96;

    localparam verdict_t VERDICT_EQUAL     = 3'd0;
    localparam verdict_t VERDICT_LESS      = 3'd1;
    localparam verdict_t VERDICT_GREATER   = 3'd2;
    localparam verdict_t VERDICT_UNDECIDED = 3'd3;
    localparam verdict_t VERDICT_INVALID   = 3'd4;

endpackage

`default_nettype wire

// ----- src/substring_lex_compare_hash_top.sv -----
`default_nettype none

// Substring compare by rolling hash. Load words write letters into the text memory; a load
// with last set then walks the text from its end, building the power and suffix-hash tables
// with one pass of the four-stage modular multiplier per character. A compare word runs a
// binary search over the shorter range length: each probe reads the two suffix hashes and
// one power together and waits on the multiplier pair. An invalid query skips the search and
// goes straight to the result. The text_length register sets the length of the next build;
// queries use the length of the last completed build. No clearing pass after reset.
module substring_lex_compare_hash_top import slch_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [POS_W-1:0]  cfg_text_length,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_action,
    input  wire logic [11:0]       s_position,
    input  wire logic [6:0]        s_symbol,
    input  wire logic              s_last,
    input  wire logic [POS_W-1:0]  s_first_start,
    input  wire logic [POS_W-1:0]  s_first_end,
    input  wire logic [POS_W-1:0]  s_second_start,
    input  wire logic [POS_W-1:0]  s_second_end,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output verdict_t               m_verdict
);

    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int TW   = $clog2(MAX_LEN);
    localparam int CMPW = (LW > POS_W) ? LW : POS_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_BINIT    = 4'd1;
    localparam logic [3:0] ST_BISSUE   = 4'd2;
    localparam logic [3:0] ST_BWAIT    = 4'd3;
    localparam logic [3:0] ST_QBASE    = 4'd4;
    localparam logic [3:0] ST_QBASE_W  = 4'd5;
    localparam logic [3:0] ST_PRB_RD   = 4'd6;
    localparam logic [3:0] ST_PRB_MUL  = 4'd7;
    localparam logic [3:0] ST_PRB_WAIT = 4'd8;
    localparam logic [3:0] ST_PRB_CMP  = 4'd9;
    localparam logic [3:0] ST_JUDGE    = 4'd10;
    localparam logic [3:0] ST_CHAR     = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    function automatic hash_t letter_value(input logic [6:0] code);
        hash_t v;
        if (code >= LETTER_OFFSET) begin
            v = 27'(code - LETTER_OFFSET);
        end else begin
            v = HASH_MOD - 27'(LETTER_OFFSET - code);
        end
        return v;
    endfunction

    function automatic hash_t add_mod(input hash_t x, input hash_t y);
        logic [27:0] s;
        s = 28'(x) + 28'(y);
        if (s >= 28'(HASH_MOD)) begin
            s = s - 28'(HASH_MOD);
        end
        return 27'(s);
    endfunction

    function automatic hash_t sub_mod(input hash_t x, input hash_t y);
        logic [27:0] d;
        d = 28'(x) - 28'(y);
        if (d[27]) begin
            d = d + 28'(HASH_MOD);
        end
        return 27'(d);
    endfunction

    // memories
    logic [6:0] text_mem [0:MAX_LEN-1];
    hash_t      sfx_mem  [0:MAX_LEN];
    hash_t      pow_mem  [0:MAX_LEN];

    logic           text_we;
    logic [TW-1:0]  text_wa;
    logic [TW-1:0]  text_ra;
    logic [TW-1:0]  text_rb;
    logic [6:0]     text_qa_reg;
    logic [6:0]     text_qb_reg;

    logic           sfx_we;
    logic [LW-1:0]  sfx_wa;
    hash_t          sfx_wd;
    logic [LW-1:0]  sfx_ra0;
    logic [LW-1:0]  sfx_ra1;
    hash_t          sfx_q0_reg;
    hash_t          sfx_q1_reg;

    logic           pow_we;
    logic [LW-1:0]  pow_wa;
    hash_t          pow_wd;
    logic [LW-1:0]  pow_ra;
    hash_t          pow_q_reg;

    // control
    logic [3:0]       state_reg,    state_next;
    logic [POS_W-1:0] text_len_reg, text_len_next;
    logic [LW-1:0]    built_reg,    built_next;
    logic             m_valid_reg,  m_valid_next;

    // datapath
    logic [LW-1:0]    len_reg,   len_next;
    logic [LW-1:0]    idx_reg,   idx_next;
    hash_t            pw_reg,    pw_next;
    hash_t            sh_reg,    sh_next;
    logic [POS_W-1:0] a0_reg,    a0_next;
    logic [POS_W-1:0] c0_reg,    c0_next;
    logic [POS_W-1:0] len1_reg,  len1_next;
    logic [POS_W-1:0] len2_reg,  len2_next;
    logic [POS_W-1:0] lo_reg,    lo_next;
    logic [POS_W-1:0] hi_reg,    hi_next;
    logic [POS_W-1:0] mid_reg,   mid_next;
    hash_t            sa_reg,    sa_next;
    hash_t            sc_reg,    sc_next;
    hash_t            h1_reg,    h1_next;
    hash_t            h2_reg,    h2_next;
    verdict_t         res_reg,   res_next;
    verdict_t         m_verdict_reg, m_verdict_next;

    logic  mul_in_valid;
    hash_t mul_a0, mul_b0, mul_a1, mul_b1;
    logic  mul_valid;
    hash_t mul_r0, mul_r1;

    logic [LW-1:0]    len_cap;
    logic             query_bad;
    logic [POS_W-1:0] q_len1, q_len2;
    logic [POS_W:0]   mid_sum;
    logic [POS_W-1:0] mid_c;
    logic [POS_W-1:0] mid_p1;
    logic [POS_W-1:0] sfx_addr0, sfx_addr1;
    logic [POS_W-1:0] chr_addr0, chr_addr1;
    logic [LW-1:0]    back_idx;
    hash_t            sh_new;

    slch_modmul u_mul0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_in_valid),
        .op_a      (mul_a0),
        .op_b      (mul_b0),
        .out_valid (mul_valid),
        .result    (mul_r0)
    );

    slch_modmul u_mul1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_in_valid),
        .op_a      (mul_a1),
        .op_b      (mul_b1),
        .out_valid (),
        .result    (mul_r1)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    assign len_cap = (CMPW'(text_len_reg) > CMPW'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(text_len_reg);

    assign query_bad = (s_first_start == '0) || (s_first_start > s_first_end)
                    || (CMPW'(s_first_end) > CMPW'(built_reg))
                    || (s_second_start == '0) || (s_second_start > s_second_end)
                    || (CMPW'(s_second_end) > CMPW'(built_reg));

    assign q_len1 = s_first_end - s_first_start + 13'd1;
    assign q_len2 = s_second_end - s_second_start + 13'd1;

    assign mid_sum   = (POS_W+1)'(lo_reg) + (POS_W+1)'(hi_reg) - 14'd1;
    assign mid_c     = mid_sum[POS_W:1];
    assign mid_p1    = mid_c + 13'd1;
    assign sfx_addr0 = a0_reg + mid_p1;
    assign sfx_addr1 = c0_reg + mid_p1;
    assign chr_addr0 = a0_reg + lo_reg;
    assign chr_addr1 = c0_reg + lo_reg;
    assign back_idx  = len_reg - idx_reg;
    assign sh_new    = add_mod(mul_r1, letter_value(text_qa_reg));

    assign text_we = s_valid && s_ready && !s_action && (CMPW'(s_position) < CMPW'(MAX_LEN));
    assign text_wa = TW'(s_position);

    always_comb begin
        state_next     = state_reg;
        text_len_next  = text_len_reg;
        built_next     = built_reg;
        m_valid_next   = m_valid_reg;
        m_verdict_next = m_verdict_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pw_next        = pw_reg;
        sh_next        = sh_reg;
        a0_next        = a0_reg;
        c0_next        = c0_reg;
        len1_next      = len1_reg;
        len2_next      = len2_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        sa_next        = sa_reg;
        sc_next        = sc_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        res_next       = res_reg;

        mul_in_valid = 1'b0;
        mul_a0       = pw_reg;
        mul_b0       = HASH_BASE;
        mul_a1       = sh_reg;
        mul_b1       = HASH_BASE;

        text_ra = TW'(back_idx);
        text_rb = TW'(chr_addr1);
        sfx_we  = 1'b0;
        sfx_wa  = back_idx;
        sfx_wd  = sh_new;
        sfx_ra0 = LW'(a0_reg);
        sfx_ra1 = LW'(c0_reg);
        pow_we  = 1'b0;
        pow_wa  = idx_reg;
        pow_wd  = mul_r0;
        pow_ra  = LW'(mid_p1);

        if (cfg_valid) begin
            text_len_next = cfg_text_length;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_action) begin
                        if (s_last) begin
                            state_next = ST_BINIT;
                        end
                    end else begin
                        a0_next   = s_first_start - 13'd1;
                        c0_next   = s_second_start - 13'd1;
                        len1_next = q_len1;
                        len2_next = q_len2;
                        lo_next   = '0;
                        hi_next   = (q_len1 < q_len2) ? q_len1 : q_len2;
                        if (query_bad) begin
                            res_next   = VERDICT_INVALID;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_QBASE;
                        end
                    end
                end
            end
            ST_BINIT: begin
                len_next = len_cap;
                idx_next = LW'(1);
                pw_next  = 27'd1;
                sh_next  = '0;
                pow_we   = 1'b1;
                pow_wa   = '0;
                pow_wd   = 27'd1;
                sfx_we   = 1'b1;
                sfx_wa   = len_cap;
                sfx_wd   = '0;
                if (len_cap == '0) begin
                    built_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_BISSUE;
                end
            end
            ST_BISSUE: begin
                mul_in_valid = 1'b1;
                state_next   = ST_BWAIT;
            end
            ST_BWAIT: begin
                if (mul_valid) begin
                    pw_next = mul_r0;
                    sh_next = sh_new;
                    pow_we  = 1'b1;
                    sfx_we  = 1'b1;
                    if (idx_reg == len_reg) begin
                        built_next = len_reg;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + LW'(1);
                        state_next = ST_BISSUE;
                    end
                end
            end
            ST_QBASE: begin
                state_next = ST_QBASE_W;
            end
            ST_QBASE_W: begin
                sa_next    = sfx_q0_reg;
                sc_next    = sfx_q1_reg;
                state_next = ST_PRB_RD;
            end
            ST_PRB_RD: begin
                sfx_ra0 = LW'(sfx_addr0);
                sfx_ra1 = LW'(sfx_addr1);
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_c;
                    state_next = ST_PRB_MUL;
                end else begin
                    state_next = ST_JUDGE;
                end
            end
            ST_PRB_MUL: begin
                mul_in_valid = 1'b1;
                mul_a0       = sfx_q0_reg;
                mul_b0       = pow_q_reg;
                mul_a1       = sfx_q1_reg;
                mul_b1       = pow_q_reg;
                state_next   = ST_PRB_WAIT;
            end
            ST_PRB_WAIT: begin
                if (mul_valid) begin
                    h1_next    = sub_mod(sa_reg, mul_r0);
                    h2_next    = sub_mod(sc_reg, mul_r1);
                    state_next = ST_PRB_CMP;
                end
            end
            ST_PRB_CMP: begin
                if (h1_reg == h2_reg) begin
                    lo_next = mid_reg + 13'd1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_PRB_RD;
            end
            ST_JUDGE: begin
                text_ra = TW'(chr_addr0);
                if ((lo_reg >= len1_reg) && (lo_reg >= len2_reg)) begin
                    res_next   = VERDICT_EQUAL;
                    state_next = ST_DONE;
                end else if (lo_reg >= len1_reg) begin
                    res_next   = VERDICT_LESS;
                    state_next = ST_DONE;
                end else if (lo_reg >= len2_reg) begin
                    res_next   = VERDICT_GREATER;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (text_qa_reg < text_qb_reg) begin
                    res_next = VERDICT_LESS;
                end else if (text_qa_reg > text_qb_reg) begin
                    res_next = VERDICT_GREATER;
                end else begin
                    res_next = VERDICT_UNDECIDED;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_verdict_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (text_we) begin
            text_mem[text_wa] <= s_symbol;
        end
        text_qa_reg <= text_mem[text_ra];
        text_qb_reg <= text_mem[text_rb];
    end

    always_ff @(posedge aclk) begin
        if (sfx_we) begin
            sfx_mem[sfx_wa] <= sfx_wd;
        end
        sfx_q0_reg <= sfx_mem[sfx_ra0];
        sfx_q1_reg <= sfx_mem[sfx_ra1];
    end

    always_ff @(posedge aclk) begin
        if (pow_we) begin
            pow_mem[pow_wa] <= pow_wd;
        end
        pow_q_reg <= pow_mem[pow_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            text_len_reg <= 13'd1;
            built_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            text_len_reg <= text_len_next;
            built_reg    <= built_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_verdict_reg <= m_verdict_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        pw_reg        <= pw_next;
        sh_reg        <= sh_next;
        a0_reg        <= a0_next;
        c0_reg        <= c0_next;
        len1_reg      <= len1_next;
        len2_reg      <= len2_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        sa_reg        <= sa_next;
        sc_reg        <= sc_next;
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        res_reg       <= res_next;
    end

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_action) |=> !$rose(m_valid_reg))
        else $error("load word produced a result");

    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRB_RD) |-> (lo_reg <= hi_reg))
        else $error("binary search bounds crossed");

    a_build_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BISSUE) |-> ((idx_reg != '0) && (idx_reg <= len_reg)))
        else $error("build index out of range");

    a_mul_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid |-> ((state_reg == ST_BWAIT) || (state_reg == ST_PRB_WAIT)))
        else $error("multiplier result outside a wait state");

endmodule

`default_nettype wire

// ----- src/slch_modmul.sv -----
`default_nettype none

// Four-stage modular multiplier, Barrett reduction by HASH_MOD.
module slch_modmul import slch_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire hash_t op_a,
    input  wire hash_t op_b,
    output logic       out_valid,
    output hash_t      result
);

    logic [3:0]  vld_reg;
    logic [53:0] prod_reg;
    logic [55:0] qmu_reg;
    logic [28:0] low2_reg;
    logic [28:0] low3_reg;
    logic [28:0] qm_reg;
    hash_t       result_reg;

    logic [53:0] prod_next;
    logic [55:0] qmu_next;
    logic [54:0] qm_full;
    logic [28:0] r_raw;
    hash_t       result_next;

    assign prod_next = 54'(op_a) * 54'(op_b);
    assign qmu_next  = 56'(prod_reg[53:26]) * 56'(HASH_MU);
    assign qm_full   = 55'(qmu_reg[55:28]) * 55'(HASH_MOD);
    assign r_raw     = low3_reg - qm_reg;

    always_comb begin
        if (r_raw >= HASH_MOD2) begin
            result_next = 27'(r_raw - HASH_MOD2);
        end else if (r_raw >= 29'(HASH_MOD)) begin
            result_next = 27'(r_raw - 29'(HASH_MOD));
        end else begin
            result_next = 27'(r_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        qmu_reg    <= qmu_next;
        low2_reg   <= prod_reg[28:0];
        qm_reg     <= qm_full[28:0];
        low3_reg   <= low2_reg;
        result_reg <= result_next;
    end

    assign out_valid = vld_reg[3];
    assign result    = result_reg;

endmodule

`default_nettype wire
